>>> rtl/lvm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: shared package
// Default fraction width and the fixed sizes of the vector normalisation unit.
// ----------------------------------------------------------------------------
package lvm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned SCALE_BITS    = 30;
  localparam int unsigned SQRT_STEPS    = SCALE_BITS + 1;

endpackage

>>> rtl/lookat_view_matrix_top.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: top level
// Builds the top three rows of a look-at view matrix from eye, centre and up.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled;
// each result passes through the three normalisation pipelines in series,
// each of which spends one stage per square-root bit and one per quotient
// bit. A stall on the output holds the whole pipeline, so nothing is lost
// or repeated.
module lookat_view_matrix_top #(
  parameter int unsigned FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // eye_x, eye_y, eye_z, center_x, center_y, center_z, up_x, up_y, up_z
  input  logic [287:0]        s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // right_x, right_y, right_z, right_shift, upward_x, upward_y, upward_z,
  // upward_shift, back_x, back_y, back_z, back_shift, zero padding
  output logic [((9*(FRAC_BITS+2)+96+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned AW    = FRAC_BITS + 2;
  localparam int unsigned OUT_W = ((9 * AW + 96 + 7) / 8) * 8;
  localparam int unsigned ROW_W = 3 * AW + 32;
  localparam int unsigned PW1   = 32 + AW;
  localparam int unsigned PW3   = 2 * AW;
  localparam int unsigned PW5   = AW + 32;
  localparam int unsigned DW    = PW5 + 2;
  localparam logic [DW:0] RND   = (DW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [DW:0] LIM   = (DW+1)'(1) << 31;

  logic en;

  logic               t0_v_q;
  logic [2:0][32:0]   t0_diff_q;
  logic [2:0][31:0]   t0_ctr_q, t0_up_q;

  logic               nz_v;
  logic [2:0][AW-1:0] nz_u;
  logic [191:0]       nz_side;
  logic [2:0][31:0]   nz_up, nz_ctr;

  logic                    t1_v_q;
  logic signed [PW1-1:0]   t1_p_q [6];
  logic signed [PW1-1:0]   t1_p_d [6];
  logic [2:0][AW-1:0]      t1_za_q;
  logic [2:0][31:0]        t1_ctr_q;

  logic                    t2_v_q;
  logic [2:0][PW1:0]       t2_c_q, t2_c_d;
  logic [2:0][AW-1:0]      t2_za_q;
  logic [2:0][31:0]        t2_ctr_q;

  logic                    nx_v;
  logic [2:0][AW-1:0]      nx_u;
  logic [3*AW+95:0]        nx_side;
  logic [2:0][AW-1:0]      nx_za;
  logic [2:0][31:0]        nx_ctr;

  logic                    t3_v_q;
  logic signed [PW3-1:0]   t3_p_q [6];
  logic signed [PW3-1:0]   t3_p_d [6];
  logic [2:0][AW-1:0]      t3_xa_q, t3_za_q;
  logic [2:0][31:0]        t3_ctr_q;

  logic                    t4_v_q;
  logic [2:0][PW3:0]       t4_c_q, t4_c_d;
  logic [2:0][AW-1:0]      t4_xa_q, t4_za_q;
  logic [2:0][31:0]        t4_ctr_q;

  logic                    ny_v;
  logic [2:0][AW-1:0]      ny_u;
  logic [6*AW+95:0]        ny_side;
  logic [2:0][AW-1:0]      ny_xa, ny_za;
  logic [2:0][31:0]        ny_ctr;

  logic                         t5_v_q;
  logic signed [PW5-1:0]        t5_p_q [9];
  logic [2:0][2:0][AW-1:0]      t5_ax_q, t5_ax_d;

  logic                         t6_v_q;
  logic signed [DW-1:0]         t6_d_q [3];
  logic [2:0][2:0][AW-1:0]      t6_ax_q;

  logic                         out_v_q;
  logic [2:0][2:0][AW-1:0]      out_ax_q;
  logic [2:0][31:0]             out_sh_q;

  function automatic logic [31:0] neg_round(input logic signed [DW-1:0] d);
    logic [DW-1:0] m;
    logic [DW:0]   r;
    logic          big;
    m   = d[DW-1] ? (DW'(0) - DW'(d)) : DW'(d);
    r   = ({1'b0, m} + RND) >> FRAC_BITS;
    big = (r >= LIM);
    if (d[DW-1]) begin
      neg_round = big ? 32'h7FFF_FFFF : r[31:0];
    end else begin
      neg_round = big ? 32'h8000_0000 : (32'd0 - r[31:0]);
    end
  endfunction

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_v_q  <= 1'b0;
      t1_v_q  <= 1'b0;
      t2_v_q  <= 1'b0;
      t3_v_q  <= 1'b0;
      t4_v_q  <= 1'b0;
      t5_v_q  <= 1'b0;
      t6_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      t0_v_q  <= s_axis_tvalid;
      t1_v_q  <= nz_v;
      t2_v_q  <= t1_v_q;
      t3_v_q  <= nx_v;
      t4_v_q  <= t3_v_q;
      t5_v_q  <= ny_v;
      t6_v_q  <= t5_v_q;
      out_v_q <= t6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t0_diff_q[i] <= {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]}
                      - {s_axis_tdata[32*i+127], s_axis_tdata[32*i+96 +: 32]};
        t0_ctr_q[i]  <= s_axis_tdata[32*i+96 +: 32];
        t0_up_q[i]   <= s_axis_tdata[32*i+192 +: 32];
      end
    end
  end

  lvm_norm #(
    .VW        (33),
    .SIDE_W    (192),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t0_v_q),
    .vec_i   (t0_diff_q),
    .side_i  ({t0_up_q, t0_ctr_q}),
    .valid_o (nz_v),
    .unit_o  (nz_u),
    .side_o  (nz_side)
  );

  assign nz_up  = nz_side[191:96];
  assign nz_ctr = nz_side[95:0];

  for (genvar i = 0; i < 3; i++) begin : g_cross_a
    localparam int unsigned I1 = (i + 1) % 3;
    localparam int unsigned I2 = (i + 2) % 3;
    assign t1_p_d[2*i]   = PW1'($signed(nz_up[I1])) * PW1'($signed(nz_u[I2]));
    assign t1_p_d[2*i+1] = PW1'($signed(nz_up[I2])) * PW1'($signed(nz_u[I1]));
    assign t2_c_d[i]     = (PW1+1)'(t1_p_q[2*i]) - (PW1+1)'(t1_p_q[2*i+1]);
    assign t3_p_d[2*i]   = PW3'($signed(nx_za[I1])) * PW3'($signed(nx_u[I2]));
    assign t3_p_d[2*i+1] = PW3'($signed(nx_za[I2])) * PW3'($signed(nx_u[I1]));
    assign t4_c_d[i]     = (PW3+1)'(t3_p_q[2*i]) - (PW3+1)'(t3_p_q[2*i+1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_p_q   <= t1_p_d;
      t1_za_q  <= nz_u;
      t1_ctr_q <= nz_ctr;
      t2_c_q   <= t2_c_d;
      t2_za_q  <= t1_za_q;
      t2_ctr_q <= t1_ctr_q;
    end
  end

  lvm_norm #(
    .VW        (PW1 + 1),
    .SIDE_W    (3 * AW + 96),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t2_v_q),
    .vec_i   (t2_c_q),
    .side_i  ({t2_za_q, t2_ctr_q}),
    .valid_o (nx_v),
    .unit_o  (nx_u),
    .side_o  (nx_side)
  );

  assign nx_za  = nx_side[3*AW+95:96];
  assign nx_ctr = nx_side[95:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      t3_p_q   <= t3_p_d;
      t3_xa_q  <= nx_u;
      t3_za_q  <= nx_za;
      t3_ctr_q <= nx_ctr;
      t4_c_q   <= t4_c_d;
      t4_xa_q  <= t3_xa_q;
      t4_za_q  <= t3_za_q;
      t4_ctr_q <= t3_ctr_q;
    end
  end

  lvm_norm #(
    .VW        (PW3 + 1),
    .SIDE_W    (6 * AW + 96),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_upward (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t4_v_q),
    .vec_i   (t4_c_q),
    .side_i  ({t4_xa_q, t4_za_q, t4_ctr_q}),
    .valid_o (ny_v),
    .unit_o  (ny_u),
    .side_o  (ny_side)
  );

  assign ny_xa  = ny_side[6*AW+95:3*AW+96];
  assign ny_za  = ny_side[3*AW+95:96];
  assign ny_ctr = ny_side[95:0];

  assign t5_ax_d[0] = ny_xa;
  assign t5_ax_d[1] = ny_u;
  assign t5_ax_d[2] = ny_za;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_ax_q <= t5_ax_d;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          t5_p_q[3*r+c] <= PW5'($signed(t5_ax_d[r][c])) * PW5'($signed(ny_ctr[c]));
        end
      end
      t6_ax_q <= t5_ax_q;
      for (int r = 0; r < 3; r++) begin
        t6_d_q[r] <= DW'(t5_p_q[3*r]) + DW'(t5_p_q[3*r+1]) + DW'(t5_p_q[3*r+2]);
      end
      out_ax_q <= t6_ax_q;
      for (int r = 0; r < 3; r++) begin
        out_sh_q[r] <= neg_round(t6_d_q[r]);
      end
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_axis_tdata[r*ROW_W + c*AW +: AW] = out_ax_q[r][c];
      end
      m_axis_tdata[r*ROW_W + 3*AW +: 32] = out_sh_q[r];
    end
  end

  assign m_axis_tvalid = out_v_q;

  localparam logic signed [AW-1:0] ONE  = AW'(1) << FRAC_BITS;
  localparam logic signed [AW-1:0] MONE = AW'(0) - (AW'(1) << FRAC_BITS);

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("Input was offered ready while the output item was stalled.");

  a_zero_back_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_ax_q[2] == '0) |-> out_sh_q[2] == 32'd0)
    else $error("A zero back axis gave a non-zero translation.");

  a_zero_right_upward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_ax_q[0] == '0) |-> out_ax_q[1] == '0)
    else $error("A zero right axis gave a non-zero upward axis.");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(out_ax_q[1][0]) <= ONE) && ($signed(out_ax_q[1][0]) >= MONE) &&
      ($signed(out_ax_q[1][1]) <= ONE) && ($signed(out_ax_q[1][1]) >= MONE) &&
      ($signed(out_ax_q[1][2]) <= ONE) && ($signed(out_ax_q[1][2]) >= MONE))
    else $error("An upward axis component lies outside the unit range.");

endmodule

>>> rtl/lvm_norm.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: pipelined vector normalisation
// Scales a three-component vector to a power-of-two range, takes the integer
// square root of the sum of squares one bit a stage, and divides each
// component by the length one quotient bit a stage.
// ----------------------------------------------------------------------------
module lvm_norm #(
  parameter int unsigned VW        = 33,
  parameter int unsigned SIDE_W    = 1,
  parameter int unsigned FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [2:0][VW-1:0]          vec_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [2:0][FRAC_BITS+1:0]   unit_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned SB  = lvm_pkg::SCALE_BITS;
  localparam int unsigned SQ  = lvm_pkg::SQRT_STEPS;
  localparam int unsigned SQW = 2 * SB + 3;
  localparam int unsigned LW  = SB + 1;
  localparam int unsigned DS  = FRAC_BITS + 1;
  localparam int unsigned RW  = SB + 1 + FRAC_BITS;
  localparam int unsigned AW  = FRAC_BITS + 2;
  localparam int unsigned BLW = $clog2(VW + 1);
  localparam int unsigned MW  = SIDE_W + 4;
  localparam int unsigned LAT = SQ + DS + 7;

  logic [MW-1:0]            meta_q [LAT];
  logic [LAT-1:0]           vld_q;
  logic [MW-1:0]            meta_d;

  logic [2:0][VW-1:0]       mag0_q, mag0_d, mag1_q;
  logic [VW-1:0]            or_all;
  logic [BLW-1:0]           bl_q, bl_d;
  logic [2:0][VW+SB-1:0]    sh_t;
  logic [2:0][SB-1:0]       sc_q, sc_d, sc3_q;
  logic [2:0][2*SB-1:0]     sqr_q;

  logic [SQW-1:0]           sn_q [SQ+1];
  logic [SQW-1:0]           sr_q [SQ+1];
  logic [2:0][SB-1:0]       sa_q [SQ+1];

  logic [2:0][RW-1:0]       dr_q [DS+1];
  logic [2:0][DS-1:0]       dq_q [DS+1];
  logic [LW-1:0]            dl_q [DS+1];

  logic [2:0][AW-1:0]       u_q, u_d;

  always_comb begin
    meta_d[3] = (vec_i[0] == '0) && (vec_i[1] == '0) && (vec_i[2] == '0);
    meta_d[MW-1:4] = side_i;
    for (int i = 0; i < 3; i++) begin
      meta_d[i]  = vec_i[i][VW-1];
      mag0_d[i]  = vec_i[i][VW-1] ? (VW'(0) - vec_i[i]) : vec_i[i];
    end
  end

  always_comb begin
    or_all = mag0_q[0] | mag0_q[1] | mag0_q[2];
    bl_d   = '0;
    for (int b = 0; b < VW; b++) begin
      if (or_all[b]) begin
        bl_d = BLW'(b + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_t[i] = {mag1_q[i], {SB{1'b0}}} >> bl_q;
      sc_d[i] = sh_t[i][SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta_d;
      for (int k = 1; k < LAT; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      mag0_q <= mag0_d;
      mag1_q <= mag0_q;
      bl_q   <= bl_d;
      sc_q   <= sc_d;
      sc3_q  <= sc_q;
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= sc_q[i] * sc_q[i];
      end
      sn_q[0] <= SQW'(sqr_q[0]) + SQW'(sqr_q[1]) + SQW'(sqr_q[2]);
      sr_q[0] <= '0;
      sa_q[0] <= sc3_q;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ - 1 - k));
    logic [SQW-1:0] trial;
    logic [SQW-1:0] n_d;
    logic [SQW-1:0] r_d;

    always_comb begin
      trial = sr_q[k] + BIT;
      if (sn_q[k] >= trial) begin
        n_d = sn_q[k] - trial;
        r_d = (sr_q[k] >> 1) + BIT;
      end else begin
        n_d = sn_q[k];
        r_d = sr_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sn_q[k+1] <= n_d;
        sr_q[k+1] <= r_d;
        sa_q[k+1] <= sa_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q[0] <= sr_q[SQ][LW-1:0];
      dq_q[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= RW'({sa_q[SQ][i], {FRAC_BITS{1'b0}}}) + RW'(sr_q[SQ][LW-1:1]);
      end
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    localparam int unsigned J = FRAC_BITS - s;
    logic [RW-1:0]          dv;
    logic [2:0][RW-1:0]     r_d;
    logic [2:0][DS-1:0]     q_d;

    always_comb begin
      dv = RW'(dl_q[s]) << J;
      for (int i = 0; i < 3; i++) begin
        r_d[i] = dr_q[s][i];
        q_d[i] = dq_q[s][i];
        if (dr_q[s][i] >= dv) begin
          r_d[i]    = dr_q[s][i] - dv;
          q_d[i][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[s+1] <= r_d;
        dq_q[s+1] <= q_d;
        dl_q[s+1] <= dl_q[s];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (meta_q[LAT-2][3]) begin
        u_d[i] = '0;
      end else if (meta_q[LAT-2][i]) begin
        u_d[i] = AW'(0) - AW'(dq_q[DS][i]);
      end else begin
        u_d[i] = AW'(dq_q[DS][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q <= u_d;
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign unit_o  = u_q;
  assign side_o  = meta_q[LAT-1][MW-1:4];

endmodule
